### rtl/i2c_master_register_access_unit_macros.svh
// Assertion macros for the I2C master register access unit.
`ifndef I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH

// Check that the antecedent always brings the consequent in the same cycle.
`define I2CMRA_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cmra: implication check failed");

// Check that two conditions never hold together.
`define I2CMRA_ASSERT_EXCL(name, clk, rst, a, b) \
   name: assert property (@(posedge clk) disable iff (rst) !((a) && (b))) \
      else $error("i2cmra: exclusion check failed");

`endif

### rtl/i2cmra_pkg.sv
// Package: types, codes and constants of the I2C master register access unit.
`default_nettype none
package i2cmra_pkg;

   localparam int DIVIDER_WIDTH_DEFAULT = 16;
   localparam int CSR_INDEX_WIDTH       = 2;
   localparam int CSR_DATA_WIDTH        = 16;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd16;
   localparam logic [9:0]  ACK_TIMEOUT_RESET = 10'd250;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACK_TIMEOUT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WIDE_ADDR   = 2'd2;

   // Request function codes
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Completion status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DEV_NACK = 2'd1;
   localparam logic [1:0] STATUS_REG_NACK = 2'd2;
   localparam logic [1:0] STATUS_DAT_NACK = 2'd3;

   typedef struct packed {
      logic [15:0] half_period_ticks;
      logic [9:0]  ack_timeout_ticks;
      logic        wide_register_address;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [6:0]  device_address;
      logic [15:0] register_address;
      logic [15:0] byte_count;
      logic [7:0]  write_byte;
      logic        sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive_low;
      logic       busy_res;
      logic       byte_taken;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/i2cmra_if.sv
// Channel interfaces: request, response and configuration write.
`default_nettype none
interface i2cmra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [6:0]  device_address;
   logic [15:0] register_address;
   logic [15:0] byte_count;
   logic [7:0]  write_byte;
   logic        sda_level;

   modport source (output valid, func, device_address, register_address, byte_count,
                   write_byte, sda_level, input ready);
   modport sink (input valid, func, device_address, register_address, byte_count,
                 write_byte, sda_level, output ready);
endinterface

interface i2cmra_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_drive_low;
   logic       busy_res;
   logic       byte_taken;
   logic [7:0] read_byte;
   logic       read_valid;
   logic       read_last;
   logic       done_res;
   logic [1:0] status;

   modport source (output valid, scl_level, sda_drive_low, busy_res, byte_taken, read_byte,
                   read_valid, read_last, done_res, status, input ready);
   modport sink (input valid, scl_level, sda_drive_low, busy_res, byte_taken, read_byte,
                 read_valid, read_last, done_res, status, output ready);
endinterface

interface i2cmra_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/i2c_master_register_access_unit.sv
// Top level of the I2C master register access unit.
//
// Usage: every request transaction on req_if is one bus tick carrying the
// sampled SDA level; in idle, func selects a register write or read start
// with device address, register address and byte count. Every request
// yields exactly one response transaction on rsp_if with the SCL level,
// SDA pull-down, busy flag, write-byte take strobe, received byte with
// valid/last marks, and the done strobe with completion status.
// A response is registered and valid in the cycle after its request is accepted.
// Throughput: one tick per clock while rsp_if does not stall; the sequencer's
// next-state logic and the single response register set this figure.
// Stall: when rsp_if stalls, the response register holds and req_if.ready
// drops until the waiting response is taken; no tick is lost.
// csr_if writes the segment length, ACK timeout and wide-address mode;
// it is always ready and writes take effect on the next tick.
// Reset (synchronous, active high): sequencer idle, response register
// empty, configuration back to 16 ticks, 250 ticks timeout, narrow mode.
`default_nettype none
`include "i2c_master_register_access_unit_macros.svh"
module i2c_master_register_access_unit
   import i2cmra_pkg::*;
#(
   parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEFAULT
) (
   input wire logic     clock,
   input wire logic     reset,
   i2cmra_req_if.sink   req_if,
   i2cmra_rsp_if.source rsp_if,
   i2cmra_csr_if.sink   csr_if
);

   cfg_type cfg_ff;
   req_type req;
   rsp_type eng_rsp, out_rsp;
   logic    accept, in_ready, out_valid;

   // Configuration registers: always ready, decode by index, drop others.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks     <= HALF_PERIOD_RESET;
         cfg_ff.ack_timeout_ticks     <= ACK_TIMEOUT_RESET;
         cfg_ff.wide_register_address <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_HALF_PERIOD: cfg_ff.half_period_ticks     <= csr_if.data;
            REG_ACK_TIMEOUT: cfg_ff.ack_timeout_ticks     <= csr_if.data[9:0];
            REG_WIDE_ADDR:   cfg_ff.wide_register_address <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   // Gather the request payload.
   assign req.func             = req_if.func;
   assign req.device_address   = req_if.device_address;
   assign req.register_address = req_if.register_address;
   assign req.byte_count       = req_if.byte_count;
   assign req.write_byte       = req_if.write_byte;
   assign req.sda_level        = req_if.sda_level;

   // Accept a tick whenever the response register has room this cycle.
   assign req_if.ready = in_ready;
   assign accept       = req_if.valid && in_ready;

   i2cmra_engine #(
      .DIVIDER_WIDTH(DIVIDER_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (cfg_ff),
      .req    (req),
      .rsp    (eng_rsp)
   );

   i2cmra_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (eng_rsp),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_rsp)
   );

   // Drive the response channel.
   assign rsp_if.valid         = out_valid;
   assign rsp_if.scl_level     = out_rsp.scl_level;
   assign rsp_if.sda_drive_low = out_rsp.sda_drive_low;
   assign rsp_if.busy_res      = out_rsp.busy_res;
   assign rsp_if.byte_taken    = out_rsp.byte_taken;
   assign rsp_if.read_byte     = out_rsp.read_byte;
   assign rsp_if.read_valid    = out_rsp.read_valid;
   assign rsp_if.read_last     = out_rsp.read_last;
   assign rsp_if.done_res      = out_rsp.done_res;
   assign rsp_if.status        = out_rsp.status;

   // Checks on the sequencer and the response register.
   `I2CMRA_ASSERT_IMPLY(a_done_busy, clock, reset, rsp_if.valid && rsp_if.done_res, rsp_if.busy_res)
   `I2CMRA_ASSERT_IMPLY(a_status_done, clock, reset, rsp_if.valid && rsp_if.status != STATUS_OK, rsp_if.done_res)
   `I2CMRA_ASSERT_EXCL(a_take_read, clock, reset, rsp_if.valid && rsp_if.byte_taken, rsp_if.read_valid)
   `I2CMRA_ASSERT_EXCL(a_stall_block, clock, reset, rsp_if.valid && !rsp_if.ready, req_if.ready)

endmodule
`default_nettype wire

### rtl/i2cmra_engine.sv
// Bus sequencer: phase state, counters and per-tick line levels.
`default_nettype none
module i2cmra_engine
   import i2cmra_pkg::*;
#(
   parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire cfg_type cfg,
   input  wire req_type req,
   output rsp_type      rsp
);

   localparam int LW = (DIVIDER_WIDTH > 16) ? DIVIDER_WIDTH : 16;
   localparam logic [LW:0] SEG_MAX = (LW+1)'((65'd1 << DIVIDER_WIDTH) - 65'd1);

   localparam logic [4:0] PH_IDLE      = 5'd0;
   localparam logic [4:0] PH_ST_HIGH   = 5'd1;
   localparam logic [4:0] PH_ST_LOW    = 5'd2;
   localparam logic [4:0] PH_TX_LOW    = 5'd3;
   localparam logic [4:0] PH_TX_HIGH   = 5'd4;
   localparam logic [4:0] PH_ACK_WAIT  = 5'd5;
   localparam logic [4:0] PH_ACK_HIGH  = 5'd6;
   localparam logic [4:0] PH_RX_LOW    = 5'd7;
   localparam logic [4:0] PH_RX_HIGH   = 5'd8;
   localparam logic [4:0] PH_MACK_LOW  = 5'd9;
   localparam logic [4:0] PH_MACK_HIGH = 5'd10;
   localparam logic [4:0] PH_RS_LOW    = 5'd11;
   localparam logic [4:0] PH_STOP_A    = 5'd12;
   localparam logic [4:0] PH_STOP_B    = 5'd13;
   localparam logic [4:0] PH_STOP_C    = 5'd14;

   localparam logic [2:0] SG_DEV_W  = 3'd0;
   localparam logic [2:0] SG_REG_HI = 3'd1;
   localparam logic [2:0] SG_REG_LO = 3'd2;
   localparam logic [2:0] SG_DATA   = 3'd3;
   localparam logic [2:0] SG_DEV_R  = 3'd4;

   logic [4:0]               phase_ff, phase_in;
   logic [2:0]               bit_ff, bit_in;
   logic [DIVIDER_WIDTH-1:0] tick_ff, tick_in;
   logic [9:0]               tmo_ff, tmo_in;
   logic [7:0]               shift_ff, shift_in;
   logic [15:0]              left_ff, left_in;
   logic [6:0]               dev_ff, dev_in;
   logic [15:0]              regad_ff, regad_in;
   logic                     rd_ff, rd_in;
   logic [2:0]               stage_ff, stage_in;
   logic [1:0]               abort_ff, abort_in;

   logic [LW:0] hp_ext, lim, tick_next;
   logic        ends, bitv;
   logic [7:0]  rx_byte;

   always_comb begin
      hp_ext = (LW+1)'(cfg.half_period_ticks);
      lim = (hp_ext > SEG_MAX) ? SEG_MAX : hp_ext;
      if (lim == '0) begin
         lim = (LW+1)'(1);
      end
      tick_next = (LW+1)'(tick_ff) + (LW+1)'(1);
      ends = (tick_next >= lim);
   end

   assign bitv = shift_ff[bit_ff];
   assign rx_byte = {shift_ff[6:0], req.sda_level};

   always_comb begin
      rsp = '0;
      rsp.busy_res = (phase_ff != PH_IDLE);
      case (phase_ff)
         PH_IDLE:      begin rsp.scl_level = 1'b1; rsp.sda_drive_low = 1'b0; end
         PH_ST_HIGH:   begin rsp.scl_level = 1'b1; rsp.sda_drive_low = 1'b0; end
         PH_ST_LOW:    begin rsp.scl_level = 1'b1; rsp.sda_drive_low = 1'b1; end
         PH_TX_LOW:    begin rsp.scl_level = 1'b0; rsp.sda_drive_low = ~bitv; end
         PH_TX_HIGH:   begin rsp.scl_level = 1'b1; rsp.sda_drive_low = ~bitv; end
         PH_ACK_WAIT:  begin rsp.scl_level = 1'b0; rsp.sda_drive_low = 1'b0; end
         PH_ACK_HIGH:  begin rsp.scl_level = 1'b1; rsp.sda_drive_low = 1'b0; end
         PH_RX_LOW:    begin rsp.scl_level = 1'b0; rsp.sda_drive_low = 1'b0; end
         PH_RX_HIGH:   begin rsp.scl_level = 1'b1; rsp.sda_drive_low = 1'b0; end
         PH_MACK_LOW:  begin rsp.scl_level = 1'b0; rsp.sda_drive_low = (left_ff != '0); end
         PH_MACK_HIGH: begin rsp.scl_level = 1'b1; rsp.sda_drive_low = (left_ff != '0); end
         PH_RS_LOW:    begin rsp.scl_level = 1'b0; rsp.sda_drive_low = 1'b0; end
         PH_STOP_A:    begin rsp.scl_level = 1'b0; rsp.sda_drive_low = 1'b1; end
         PH_STOP_B:    begin rsp.scl_level = 1'b1; rsp.sda_drive_low = 1'b1; end
         default:      begin rsp.scl_level = 1'b1; rsp.sda_drive_low = 1'b0; end
      endcase

      phase_in = phase_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      tmo_in   = tmo_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      dev_in   = dev_ff;
      regad_in = regad_ff;
      rd_in    = rd_ff;
      stage_in = stage_ff;
      abort_in = abort_ff;

      if (phase_ff == PH_IDLE) begin
         tick_in = '0;
         if (req.func == FUNC_WRITE || req.func == FUNC_READ) begin
            dev_in   = req.device_address;
            regad_in = req.register_address;
            left_in  = req.byte_count;
            rd_in    = (req.func == FUNC_READ);
            abort_in = STATUS_OK;
            stage_in = SG_DEV_W;
            phase_in = PH_ST_HIGH;
         end
      end else if (phase_ff == PH_ACK_WAIT) begin
         tick_in = '0;
         if (!req.sda_level) begin
            tmo_in   = '0;
            phase_in = PH_ACK_HIGH;
         end else if (tmo_ff >= cfg.ack_timeout_ticks) begin
            tmo_in = '0;
            if (stage_ff == SG_DEV_W) begin
               abort_in = STATUS_DEV_NACK;
            end else if (stage_ff == SG_REG_HI || stage_ff == SG_REG_LO) begin
               abort_in = STATUS_REG_NACK;
            end else begin
               abort_in = STATUS_DAT_NACK;
            end
            phase_in = PH_STOP_A;
         end else begin
            tmo_in = tmo_ff + 10'd1;
         end
      end else if (!ends) begin
         tick_in = tick_ff + DIVIDER_WIDTH'(1);
      end else begin
         tick_in = '0;
         case (phase_ff)
            PH_ST_HIGH: phase_in = PH_ST_LOW;
            PH_ST_LOW: begin
               shift_in = (stage_ff == SG_DEV_R) ? {dev_ff, 1'b1} : {dev_ff, 1'b0};
               stage_in = (stage_ff == SG_DEV_R) ? SG_DEV_R : SG_DEV_W;
               bit_in   = 3'd7;
               phase_in = PH_TX_LOW;
            end
            PH_TX_LOW: phase_in = PH_TX_HIGH;
            PH_TX_HIGH: begin
               if (bit_ff == 3'd0) begin
                  tmo_in   = '0;
                  phase_in = PH_ACK_WAIT;
               end else begin
                  bit_in   = bit_ff - 3'd1;
                  phase_in = PH_TX_LOW;
               end
            end
            PH_ACK_HIGH: begin
               if (stage_ff == SG_DEV_W) begin
                  shift_in = cfg.wide_register_address ? regad_ff[15:8] : regad_ff[7:0];
                  stage_in = cfg.wide_register_address ? SG_REG_HI : SG_REG_LO;
                  bit_in   = 3'd7;
                  phase_in = PH_TX_LOW;
               end else if (stage_ff == SG_REG_HI) begin
                  shift_in = regad_ff[7:0];
                  stage_in = SG_REG_LO;
                  bit_in   = 3'd7;
                  phase_in = PH_TX_LOW;
               end else if (stage_ff == SG_DEV_R) begin
                  if (left_ff == '0) begin
                     phase_in = PH_STOP_A;
                  end else begin
                     shift_in = '0;
                     bit_in   = 3'd7;
                     phase_in = PH_RX_LOW;
                  end
               end else if (stage_ff == SG_REG_LO && rd_ff) begin
                  stage_in = SG_DEV_R;
                  phase_in = PH_RS_LOW;
               end else if (left_ff == '0) begin
                  phase_in = PH_STOP_A;
               end else begin
                  rsp.byte_taken = 1'b1;
                  left_in  = left_ff - 16'd1;
                  shift_in = req.write_byte;
                  stage_in = SG_DATA;
                  bit_in   = 3'd7;
                  phase_in = PH_TX_LOW;
               end
            end
            PH_RX_LOW: phase_in = PH_RX_HIGH;
            PH_RX_HIGH: begin
               shift_in = rx_byte;
               if (bit_ff == 3'd0) begin
                  rsp.read_byte  = rx_byte;
                  rsp.read_valid = 1'b1;
                  rsp.read_last  = (left_ff == 16'd1);
                  left_in  = left_ff - 16'd1;
                  phase_in = PH_MACK_LOW;
               end else begin
                  bit_in   = bit_ff - 3'd1;
                  phase_in = PH_RX_LOW;
               end
            end
            PH_MACK_LOW: phase_in = PH_MACK_HIGH;
            PH_MACK_HIGH: begin
               if (left_ff == '0) begin
                  phase_in = PH_STOP_A;
               end else begin
                  shift_in = '0;
                  bit_in   = 3'd7;
                  phase_in = PH_RX_LOW;
               end
            end
            PH_RS_LOW: phase_in = PH_ST_HIGH;
            PH_STOP_A: phase_in = PH_STOP_B;
            PH_STOP_B: phase_in = PH_STOP_C;
            default: begin
               // final STOP segment and any stray code: finish and report
               rsp.done_res = 1'b1;
               rsp.status   = abort_ff;
               abort_in = STATUS_OK;
               bit_in   = 3'd7;
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 3'd7;
         tick_ff  <= '0;
         tmo_ff   <= '0;
         shift_ff <= '0;
         left_ff  <= '0;
         dev_ff   <= '0;
         regad_ff <= '0;
         rd_ff    <= 1'b0;
         stage_ff <= SG_DEV_W;
         abort_ff <= STATUS_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         tmo_ff   <= tmo_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         dev_ff   <= dev_in;
         regad_ff <= regad_in;
         rd_ff    <= rd_in;
         stage_ff <= stage_in;
         abort_ff <= abort_in;
      end
   end

endmodule
`default_nettype wire

### rtl/i2cmra_rsp_reg.sv
// Response output register with valid/ready handshake.
`default_nettype none
module i2cmra_rsp_reg
   import i2cmra_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule
`default_nettype wire
